// ----- sv/falc_pkg.sv -----
// Shared constants, operation codes and the controller state type of the line cache.
`default_nettype none

package falc_pkg;

   // Fixed field widths of the request and response words
   localparam int FUNC_W         = 2;
   localparam int ADDR_W         = 32;
   localparam int WORD_W         = 64;
   localparam int WORDS_PER_LINE = 8;
   localparam int WIDX_W         = $clog2(WORDS_PER_LINE);
   localparam int WK_W           = $clog2(WORDS_PER_LINE + 1);
   localparam int OFFSET_W       = $clog2(WORDS_PER_LINE * 8);
   localparam int TAG_W          = ADDR_W - OFFSET_W;
   localparam int STAMP_W        = 32;
   localparam int META_W         = TAG_W + STAMP_W;
   localparam int LINES_DEFAULT  = 16;

   // Packed stream widths, padded to whole bytes
   localparam int REQ_DATA_W = ((ADDR_W + WIDX_W + WORD_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((WORD_W + WIDX_W + 7) / 8) * 8;
   localparam int RSP_PAD_W  = RSP_DATA_W - WORD_W - WIDX_W;

   localparam logic [STAMP_W-1:0] STAMP_MAX = 32'hFFFF_FFFF;
   localparam logic [WIDX_W-1:0]  LAST_WORD = WIDX_W'(WORDS_PER_LINE - 1);

   // Operation codes carried on req_tuser
   localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_FILL   = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_EVICT  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_MISS,
      ST_STREAM,
      ST_CLEAR
   } state_type;

endpackage

`default_nettype wire

// ----- sv/fully_associative_lru_line_cache_core.sv -----
// Top level: fully associative line cache with LRU replacement by use stamps.
//
// Request channel (req_): one word per operation; req_tuser selects lookup,
// fill word or evict. Response channel (rsp_): lookup results only; a hit
// gives one word per line word in order with rsp_tlast on the final one, a
// miss gives a single word with rsp_tuser (hit) low and rsp_tlast high.
// Fill and evict give no response.
// Timing: a fill word that continues a line is written to the word memory as
// it is accepted. Lookup, evict and fill start scan the tag/stamp memory one
// line per cycle; a hit then streams one line word per cycle unless
// rsp_tready holds it back, and an evict that hits zeroes the line in the
// word memory word by word. The single read port of the tag/stamp memory
// sets the scan rate.
// Reset: synchronous, active high; clears all valid bits, the use counter,
// the fill target and the response valid flag. No clearing pass is needed.
// Backpressure: the response register holds while rsp_tready is low and the
// line stream pauses; a new request is taken as soon as the last response
// word sits in the register, before it is taken.
`default_nettype none

module fully_associative_lru_line_cache_core #(
   parameter int LINES = falc_pkg::LINES_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // req_tdata, low bit up: real_address[31:0], word_index[2:0], fill_word[63:0], zero pad
   input  wire logic [falc_pkg::REQ_DATA_W-1:0]   req_tdata,
   // req_tuser: func[1:0]
   input  wire logic [falc_pkg::FUNC_W-1:0]       req_tuser,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // rsp_tdata, low bit up: read_word[63:0], out_index[2:0], zero pad
   output logic      [falc_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // rsp_tuser: hit
   output logic                                   rsp_tuser,
   output logic                                   rsp_tlast
);

   import falc_pkg::*;

   localparam int LW    = $clog2(LINES);
   localparam int WA_W  = $clog2(LINES * WORDS_PER_LINE);
   localparam logic [LW-1:0] LAST_LINE = LW'(LINES - 1);

   // request fields
   logic [ADDR_W-1:0] req_addr;
   logic [WIDX_W-1:0] req_widx;
   logic [WORD_W-1:0] req_word;
   logic [TAG_W-1:0]  req_tag;

   assign req_addr = req_tdata[ADDR_W-1:0];
   assign req_widx = req_tdata[ADDR_W +: WIDX_W];
   assign req_word = req_tdata[ADDR_W + WIDX_W +: WORD_W];
   assign req_tag  = req_addr[ADDR_W-1:OFFSET_W];

   // registers and next values
   state_type state_ff, state_in;
   logic [FUNC_W-1:0]  op_ff, op_in;
   logic [TAG_W-1:0]   tag_ff, tag_in;
   logic [WORD_W-1:0]  word0_ff, word0_in;
   logic [STAMP_W-1:0] use_counter_ff, use_counter_in;
   logic [LW-1:0]      fill_target_ff, fill_target_in;
   logic [LINES-1:0]   valid_ff, valid_in;
   logic [LW-1:0]      issue_idx_ff, issue_idx_in;
   logic               issue_more_ff, issue_more_in;
   logic               chk_vld_ff, chk_vld_in;
   logic [LW-1:0]      chk_idx_ff, chk_idx_in;
   logic               found_ff, found_in;
   logic [LW-1:0]      match_idx_ff, match_idx_in;
   logic [STAMP_W-1:0] least_ff, least_in;
   logic [LW-1:0]      best_idx_ff, best_idx_in;
   logic [WK_W-1:0]    word_k_ff, word_k_in;
   logic               rd_pend_ff, rd_pend_in;
   logic [WIDX_W-1:0]  rd_k_ff, rd_k_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_hit_ff, rsp_hit_in;
   logic [WORD_W-1:0]  rsp_word_ff, rsp_word_in;
   logic [WIDX_W-1:0]  rsp_index_ff, rsp_index_in;
   logic               rsp_last_ff, rsp_last_in;

   // control decode
   logic req_accept_c, is_start_c, fill_cont_c, out_free_c;
   logic stream_load_c, stream_issue_c, stream_end_c, miss_load_c, clear_end_c;
   logic [LW-1:0] target_c;

   // memory ports
   logic               meta_rd_en, meta_wr_en;
   logic [LW-1:0]      meta_wr_addr;
   logic [META_W-1:0]  meta_wr_data, meta_rd_data;
   logic               words_rd_en, words_wr_en;
   logic [WA_W-1:0]    words_rd_addr, words_wr_addr;
   logic [WORD_W-1:0]  words_wr_data, words_rd_data;

   // scan compare
   logic               chk_act_c, chk_line_valid, chk_match;
   logic [TAG_W-1:0]   chk_tag;
   logic [STAMP_W-1:0] chk_stamp;

   // tag and stamp of each line
   falc_ram #(.WIDTH(META_W), .DEPTH(LINES)) u_meta_ram (
      .clock   (clock),
      .wr_en   (meta_wr_en),
      .wr_addr (meta_wr_addr),
      .wr_data (meta_wr_data),
      .rd_en   (meta_rd_en),
      .rd_addr (issue_idx_ff),
      .rd_data (meta_rd_data)
   );

   // line contents, addressed {line, word}
   falc_ram #(.WIDTH(WORD_W), .DEPTH(LINES * WORDS_PER_LINE)) u_words_ram (
      .clock   (clock),
      .wr_en   (words_wr_en),
      .wr_addr (words_wr_addr),
      .wr_data (words_wr_data),
      .rd_en   (words_rd_en),
      .rd_addr (words_rd_addr),
      .rd_data (words_rd_data)
   );

   // handshake and sequencing decode
   always_comb begin
      req_tready     = (state_ff == ST_IDLE);
      req_accept_c   = req_tvalid && req_tready;
      is_start_c     = (req_tuser == FUNC_LOOKUP) || (req_tuser == FUNC_EVICT) ||
                       ((req_tuser == FUNC_FILL) && (req_widx == '0));
      fill_cont_c    = req_accept_c && (req_tuser == FUNC_FILL) && (req_widx != '0);
      out_free_c     = !rsp_valid_ff || rsp_tready;
      stream_load_c  = (state_ff == ST_STREAM) && rd_pend_ff && out_free_c;
      stream_issue_c = (state_ff == ST_STREAM) && (word_k_ff < WK_W'(WORDS_PER_LINE)) &&
                       (!rd_pend_ff || stream_load_c);
      stream_end_c   = stream_load_c && (rd_k_ff == LAST_WORD);
      miss_load_c    = (state_ff == ST_MISS) && out_free_c;
      clear_end_c    = (state_ff == ST_CLEAR) && (word_k_ff[WIDX_W-1:0] == LAST_WORD);
      target_c       = found_ff ? match_idx_ff : best_idx_ff;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept_c && is_start_c) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (found_ff || (!issue_more_ff && !chk_vld_ff)) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            case (op_ff)
               FUNC_LOOKUP: state_in = found_ff ? ST_STREAM : ST_MISS;
               FUNC_EVICT:  state_in = found_ff ? ST_CLEAR : ST_IDLE;
               default:     state_in = ST_IDLE;
            endcase
         end
         ST_MISS: begin
            if (miss_load_c) begin
               state_in = ST_IDLE;
            end
         end
         ST_STREAM: begin
            if (stream_end_c) begin
               state_in = ST_IDLE;
            end
         end
         ST_CLEAR: begin
            if (clear_end_c) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // memory port control
   always_comb begin
      meta_rd_en    = (state_ff == ST_SCAN) && issue_more_ff;
      meta_wr_en    = 1'b0;
      meta_wr_addr  = target_c;
      meta_wr_data  = {tag_ff, use_counter_ff};
      words_rd_en   = stream_issue_c;
      words_rd_addr = {match_idx_ff, word_k_ff[WIDX_W-1:0]};
      words_wr_en   = 1'b0;
      words_wr_addr = {fill_target_ff, req_widx};
      words_wr_data = req_word;
      if (fill_cont_c) begin
         words_wr_en = 1'b1;
      end
      if (state_ff == ST_DECIDE) begin
         if ((op_ff == FUNC_LOOKUP) && found_ff) begin
            // hit takes the second count as its stamp
            meta_wr_en   = 1'b1;
            meta_wr_data = {tag_ff, use_counter_ff + STAMP_W'(1)};
         end else if (op_ff == FUNC_FILL) begin
            meta_wr_en    = 1'b1;
            words_wr_en   = 1'b1;
            words_wr_addr = {target_c, WIDX_W'(0)};
            words_wr_data = word0_ff;
         end
      end
      if (state_ff == ST_CLEAR) begin
         words_wr_en   = 1'b1;
         words_wr_addr = {match_idx_ff, word_k_ff[WIDX_W-1:0]};
         words_wr_data = '0;
      end
   end

   // scan compare on the line read last cycle; invalid lines count as stamp zero
   always_comb begin
      chk_tag        = meta_rd_data[META_W-1:STAMP_W];
      chk_stamp      = valid_ff[chk_idx_ff] ? meta_rd_data[STAMP_W-1:0] : '0;
      chk_line_valid = valid_ff[chk_idx_ff];
      chk_match      = chk_line_valid && (chk_tag == tag_ff);
      chk_act_c      = (state_ff == ST_SCAN) && chk_vld_ff && !found_ff;
   end

   // datapath next values
   always_comb begin
      op_in          = op_ff;
      tag_in         = tag_ff;
      word0_in       = word0_ff;
      use_counter_in = use_counter_ff;
      fill_target_in = fill_target_ff;
      valid_in       = valid_ff;
      issue_idx_in   = issue_idx_ff;
      issue_more_in  = issue_more_ff;
      chk_vld_in     = 1'b0;
      chk_idx_in     = issue_idx_ff;
      found_in       = found_ff;
      match_idx_in   = match_idx_ff;
      least_in       = least_ff;
      best_idx_in    = best_idx_ff;
      word_k_in      = word_k_ff;
      rd_pend_in     = rd_pend_ff;
      rd_k_in        = rd_k_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_hit_in     = rsp_hit_ff;
      rsp_word_in    = rsp_word_ff;
      rsp_index_in   = rsp_index_ff;
      rsp_last_in    = rsp_last_ff;

      // start of a searching operation
      if (req_accept_c && is_start_c) begin
         op_in          = req_tuser;
         tag_in         = req_tag;
         word0_in       = req_word;
         use_counter_in = use_counter_ff + STAMP_W'(1);
         issue_idx_in   = '0;
         issue_more_in  = 1'b1;
         found_in       = 1'b0;
         least_in       = STAMP_MAX;
         best_idx_in    = '0;
      end

      // walk the tag/stamp memory
      if (state_ff == ST_SCAN) begin
         chk_vld_in = issue_more_ff;
         if (issue_more_ff) begin
            if (issue_idx_ff == LAST_LINE) begin
               issue_more_in = 1'b0;
            end else begin
               issue_idx_in = issue_idx_ff + LW'(1);
            end
         end
      end
      if (chk_act_c) begin
         if (chk_match) begin
            found_in     = 1'b1;
            match_idx_in = chk_idx_ff;
         end else if (chk_stamp < least_ff) begin
            least_in    = chk_stamp;
            best_idx_in = chk_idx_ff;
         end
      end

      // apply the outcome
      if (state_ff == ST_DECIDE) begin
         word_k_in  = '0;
         rd_pend_in = 1'b0;
         if ((op_ff == FUNC_LOOKUP) && found_ff) begin
            use_counter_in = use_counter_ff + STAMP_W'(1);
         end else if (op_ff == FUNC_FILL) begin
            valid_in[target_c] = 1'b1;
            fill_target_in     = target_c;
         end else if ((op_ff == FUNC_EVICT) && found_ff) begin
            valid_in[match_idx_ff] = 1'b0;
         end
      end

      // line stream through the read register
      if (stream_issue_c) begin
         word_k_in  = word_k_ff + WK_W'(1);
         rd_k_in    = word_k_ff[WIDX_W-1:0];
         rd_pend_in = 1'b1;
      end else if (stream_load_c) begin
         rd_pend_in = 1'b0;
      end
      if (state_ff == ST_CLEAR) begin
         word_k_in = word_k_ff + WK_W'(1);
      end

      // response register
      if (stream_load_c) begin
         rsp_valid_in = 1'b1;
         rsp_hit_in   = 1'b1;
         rsp_word_in  = words_rd_data;
         rsp_index_in = rd_k_ff;
         rsp_last_in  = (rd_k_ff == LAST_WORD);
      end else if (miss_load_c) begin
         rsp_valid_in = 1'b1;
         rsp_hit_in   = 1'b0;
         rsp_word_in  = '0;
         rsp_index_in = '0;
         rsp_last_in  = 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         use_counter_ff <= '0;
         fill_target_ff <= '0;
         valid_ff       <= '0;
         issue_more_ff  <= 1'b0;
         chk_vld_ff     <= 1'b0;
         found_ff       <= 1'b0;
         rd_pend_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         use_counter_ff <= use_counter_in;
         fill_target_ff <= fill_target_in;
         valid_ff       <= valid_in;
         issue_more_ff  <= issue_more_in;
         chk_vld_ff     <= chk_vld_in;
         found_ff       <= found_in;
         rd_pend_ff     <= rd_pend_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      tag_ff       <= tag_in;
      word0_ff     <= word0_in;
      issue_idx_ff <= issue_idx_in;
      chk_idx_ff   <= chk_idx_in;
      match_idx_ff <= match_idx_in;
      least_ff     <= least_in;
      best_idx_ff  <= best_idx_in;
      word_k_ff    <= word_k_in;
      rd_k_ff      <= rd_k_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_word_ff  <= rsp_word_in;
      rsp_index_ff <= rsp_index_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // response port
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_index_ff, rsp_word_ff};
   assign rsp_tuser  = rsp_hit_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTH
   // a miss word is always the final, all-zero word
   a_miss_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tlast && (rsp_tdata == '0))
      else $error("miss response not last or not zero");

   // lookup and evict bump the use counter once on acceptance
   a_count_bump: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && ((req_tuser == FUNC_LOOKUP) || (req_tuser == FUNC_EVICT))
      |=> use_counter_ff == $past(use_counter_ff) + STAMP_W'(1))
      else $error("use counter not bumped on access");

   // the streamed line stays valid for the whole stream
   a_stream_valid: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_STREAM |-> valid_ff[match_idx_ff])
      else $error("streaming from an invalid line");

   // an accepted lookup always enters the scan
   a_scan_entry: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == FUNC_LOOKUP) |=> state_ff == ST_SCAN)
      else $error("lookup did not start a scan");

   // a word is only loaded into the response register while it is free
   a_rsp_overwrite: assert property (@(posedge clock) disable iff (reset)
      (stream_load_c || miss_load_c) |-> out_free_c)
      else $error("response register overwritten");
`endif

endmodule

`default_nettype wire

// ----- sv/falc_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module falc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, data holds while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire
